[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/md4_pkg.sv]
package md4_pkg;

    localparam logic [1:0] ACT_ABSORB  = 2'd0;
    localparam logic [1:0] ACT_FINISH  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] K_ROUND2 = 32'h5a827999;
    localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_IDX  = 6'd63;
    localparam logic [5:0] LAST_STEP = 6'd47;

    localparam logic [3:0] WORD_ORDER [0:47] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
        4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
        4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
    };

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    function automatic logic [4:0] rot_amount(input logic [1:0] round, input logic [1:0] j);
        logic [4:0] s;
        s = 5'd3;
        case (round)
            2'd0: begin
                case (j)
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd7;
                    2'd2:    s = 5'd11;
                    default: s = 5'd19;
                endcase
            end
            2'd1: begin
                case (j)
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd5;
                    2'd2:    s = 5'd9;
                    default: s = 5'd13;
                endcase
            end
            default: begin
                case (j)
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd9;
                    2'd2:    s = 5'd11;
                    default: s = 5'd15;
                endcase
            end
        endcase
        return s;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {32'd0, v} << s;
        return t[63:32] | t[31:0];
    endfunction

endpackage

[src/md4_front.sv]
module md4_front #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_data_byte,
    output md4_pkg::t_qhead   o_head,
    input  logic              i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    md4_pkg::t_item   r_q [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;
    logic             w_push;

    assign o_in_stall = (r_count == CNT_W'(DEPTH));
    // unused action codes are dropped here
    assign w_push = i_in_valid && !o_in_stall && (i_action != md4_pkg::ACT_UNUSED);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{action: i_action, data: i_data_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/md4_core.sv]
module md4_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  md4_pkg::t_qhead   i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_digest_byte,
    output logic [3:0]        o_byte_position,
    output logic              o_last_byte
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_ph, n_ph;
    logic        r_in_pad, n_in_pad;
    logic [31:0] r_h [4];
    logic [31:0] n_h [4];
    logic [31:0] r_a, r_b, r_c, r_d, n_a, n_b, n_c, n_d;
    logic [5:0]  r_step, n_step;
    logic [60:0] r_cnt, n_cnt;
    logic [63:0] r_len, n_len;
    logic [23:0] r_acc, n_acc;
    logic [3:0]  r_pos_cnt, n_pos_cnt;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_obyte, n_obyte;
    logic [3:0]  r_opos, n_opos;
    logic        r_olast, n_olast;

    logic [31:0] r_mem [16];
    logic [31:0] r_rdata;

    logic        w_absorb;
    logic [7:0]  w_byte;
    logic [5:0]  w_idx;
    logic        w_we;
    logic [3:0]  w_raddr;
    logic [5:0]  w_next_step;
    logic [1:0]  w_round;
    logic [31:0] w_f, w_t, w_word;
    logic [7:0]  w_len_byte;

    assign w_idx       = r_cnt[5:0];
    assign w_we        = w_absorb && (w_idx[1:0] == 2'd3);
    assign w_next_step = r_step + 6'd1;
    assign w_round     = r_step[5:4];
    assign w_len_byte  = 8'(r_len >> {w_idx[2:0], 3'b000});
    assign w_word      = r_h[r_pos_cnt[3:2]];

    always_comb begin
        case (w_round)
            2'd0:    w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    w_f = ((r_b & r_c) | (r_b & r_d) | (r_c & r_d)) + md4_pkg::K_ROUND2;
            default: w_f = (r_b ^ r_c ^ r_d) + md4_pkg::K_ROUND3;
        endcase
        w_t = md4_pkg::rotl32(r_a + w_f + r_rdata, md4_pkg::rot_amount(w_round, r_step[1:0]));
    end

    always_comb begin
        if (r_state == S_PRE) begin
            w_raddr = md4_pkg::WORD_ORDER[0];
        end else if (r_state == S_COMP && r_step != md4_pkg::LAST_STEP) begin
            w_raddr = md4_pkg::WORD_ORDER[w_next_step];
        end else begin
            w_raddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_idx[5:2]] <= {w_byte, r_acc};
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_ph        = r_ph;
        n_in_pad    = r_in_pad;
        n_h         = r_h;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_acc       = r_acc;
        n_pos_cnt   = r_pos_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_obyte     = r_obyte;
        n_opos      = r_opos;
        n_olast     = r_olast;
        o_pop       = 1'b0;
        w_absorb    = 1'b0;
        w_byte      = 8'd0;

        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.item.action)
                        md4_pkg::ACT_ABSORB: begin
                            w_absorb = 1'b1;
                            w_byte   = i_head.item.data;
                        end
                        md4_pkg::ACT_FINISH: begin
                            n_len    = {r_cnt, 3'b000};
                            n_in_pad = 1'b1;
                            n_ph     = PH_MARK;
                            n_state  = S_PAD;
                        end
                        md4_pkg::ACT_RESTART: begin
                            n_h   = '{md4_pkg::INIT_A, md4_pkg::INIT_B,
                                      md4_pkg::INIT_C, md4_pkg::INIT_D};
                            n_cnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAD: begin
                case (r_ph)
                    PH_MARK: begin
                        w_absorb = 1'b1;
                        w_byte   = md4_pkg::PAD_MARK;
                        n_ph     = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (w_idx == md4_pkg::LEN_START) begin
                            n_ph = PH_LEN;
                        end else begin
                            w_absorb = 1'b1;
                        end
                    end
                    default: begin
                        w_absorb = 1'b1;
                        w_byte   = w_len_byte;
                    end
                endcase
            end
            S_PRE: begin
                n_a     = r_h[0];
                n_b     = r_h[1];
                n_c     = r_h[2];
                n_d     = r_h[3];
                n_step  = '0;
                n_state = S_COMP;
            end
            S_COMP: begin
                n_a    = r_d;
                n_d    = r_c;
                n_c    = r_b;
                n_b    = w_t;
                n_step = w_next_step;
                if (r_step == md4_pkg::LAST_STEP) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_h[0] = r_h[0] + r_a;
                n_h[1] = r_h[1] + r_b;
                n_h[2] = r_h[2] + r_c;
                n_h[3] = r_h[3] + r_d;
                if (!r_in_pad) begin
                    n_state = S_IDLE;
                end else if (r_ph == PH_LEN) begin
                    n_pos_cnt = '0;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_obyte     = 8'(w_word >> {r_pos_cnt[1:0], 3'b000});
                    n_opos      = r_pos_cnt;
                    n_olast     = (r_pos_cnt == 4'd15);
                    n_pos_cnt   = r_pos_cnt + 4'd1;
                    if (r_pos_cnt == 4'd15) begin
                        n_h      = '{md4_pkg::INIT_A, md4_pkg::INIT_B,
                                     md4_pkg::INIT_C, md4_pkg::INIT_D};
                        n_cnt    = '0;
                        n_in_pad = 1'b0;
                        n_ph     = PH_MARK;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_absorb) begin
            n_cnt = r_cnt + 61'd1;
            n_acc = {w_byte, r_acc[23:8]};
            if (w_idx == md4_pkg::LAST_IDX) begin
                n_state = S_PRE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= PH_MARK;
            r_in_pad    <= 1'b0;
            r_h         <= '{md4_pkg::INIT_A, md4_pkg::INIT_B,
                             md4_pkg::INIT_C, md4_pkg::INIT_D};
            r_cnt       <= '0;
            r_pos_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_in_pad    <= n_in_pad;
            r_h         <= n_h;
            r_cnt       <= n_cnt;
            r_pos_cnt   <= n_pos_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_d     <= n_d;
        r_step  <= n_step;
        r_len   <= n_len;
        r_acc   <= n_acc;
        r_obyte <= n_obyte;
        r_opos  <= n_opos;
        r_olast <= n_olast;
    end

    assign o_out_valid     = r_out_valid;
    assign o_digest_byte   = r_obyte;
    assign o_byte_position = r_opos;
    assign o_last_byte     = r_olast;

endmodule

[src/md4_digest_engine.sv]
// MD4 digest engine. Items carry an action: absorb one message byte, finish, or restart.
// Items enter a small queue (QUEUE_DEPTH entries) so the input side keeps moving while the
// digest core is busy, until the queue fills; unused action codes are dropped on entry.
// Bytes are taken one per cycle while the core is idle; a byte that fills a 64-byte block
// starts a compression (one load step, 48 rounds at one round per cycle, one chaining add
// step) that takes no items. Finish pads the message one byte per cycle, with one or two
// more compressions as blocks fill and a step with no byte where the padding reaches the
// length field, then returns the 16 digest bytes, word A first and each word little-endian,
// one per cycle unless stalled, through an output register, the last one flagged, and
// starts a new message from the initial constants. Restart returns to the initial state.
`include "assert_macros.svh"

module md4_digest_engine #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_digest_byte,
    output logic [3:0] o_byte_position,
    output logic       o_last_byte
);

    md4_pkg::t_qhead w_head;
    logic            w_pop;

    md4_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    md4_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_digest_byte   (o_digest_byte),
        .o_byte_position (o_byte_position),
        .o_last_byte     (o_last_byte)
    );

    `ASSERT_SAME(a_pop_has_item, i_clk, i_rst_n, w_pop, w_head.valid)
    `ASSERT_NEXT(a_pos_steps, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last_byte, o_out_valid && (o_byte_position == $past(o_byte_position) + 4'd1))
    `ASSERT_NEXT(a_first_after_last, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_last_byte, !o_out_valid || (o_byte_position == 4'd0))

endmodule

[dv/md4_digest_engine_chk.sv]
`timescale 1ns / 100ps

module md4_digest_engine_chk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_digest_byte,
    input  logic [3:0] i_byte_position,
    input  logic       i_last_byte,
    output int         o_mismatches,
    output int         o_pending
);

    localparam logic [31:0] SEED_A = 32'h67452301;
    localparam logic [31:0] SEED_B = 32'hefcdab89;
    localparam logic [31:0] SEED_C = 32'h98badcfe;
    localparam logic [31:0] SEED_D = 32'h10325476;
    localparam logic [31:0] ADD_R2 = 32'h5a827999;
    localparam logic [31:0] ADD_R3 = 32'h6ed9eba1;

    localparam int MSG_WORD [48] = '{
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
        0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
        0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15
    };
    localparam int SHIFT [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};

    typedef struct packed {
        logic [7:0] digest;
        logic [3:0] pos;
        logic       last;
    } digest_out_t;

    logic [31:0]  chain_w [4];
    logic [63:0]  bit_total;
    logic [7:0]   blk [64];
    digest_out_t  digest_due_q [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic logic [31:0] rol(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic restart_state();
        chain_w[0] = SEED_A;
        chain_w[1] = SEED_B;
        chain_w[2] = SEED_C;
        chain_w[3] = SEED_D;
        bit_total  = '0;
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    endtask

    task automatic md4_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        for (int i = 0; i < 16; i++) w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = chain_w[0];
        b = chain_w[1];
        c = chain_w[2];
        d = chain_w[3];
        for (int i = 0; i < 48; i++) begin
            case (i / 16)
                0: f = (b & c) | (~b & d);
                1: f = ((b & c) | (b & d) | (c & d)) + ADD_R2;
                default: f = (b ^ c ^ d) + ADD_R3;
            endcase
            t = rol(a + f + w[MSG_WORD[i]], SHIFT[(i / 16) * 4 + (i % 4)]);
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain_w[0] += a;
        chain_w[1] += b;
        chain_w[2] += c;
        chain_w[3] += d;
    endtask

    task automatic md4_absorb(input logic [7:0] value);
        logic [5:0] idx;
        idx = bit_total[8:3];
        blk[idx] = value;
        bit_total += 64'd8;
        if (idx == 6'd63) md4_compress();
    endtask

    task automatic md4_take_item(input logic [1:0] act, input logic [7:0] value);
        logic [63:0] msg_bits;
        digest_out_t due;
        case (act)
            md4_pkg::ACT_ABSORB: md4_absorb(value);
            md4_pkg::ACT_RESTART: restart_state();
            md4_pkg::ACT_FINISH: begin
                msg_bits = bit_total;
                md4_absorb(8'h80);
                while (bit_total[8:3] != 6'd56) md4_absorb(8'h00);
                for (int k = 0; k < 8; k++) md4_absorb(msg_bits[8*k +: 8]);
                for (int k = 0; k < 16; k++) begin
                    due.digest = chain_w[k / 4][8 * (k % 4) +: 8];
                    due.pos    = 4'(k);
                    due.last   = (k == 15);
                    digest_due_q.push_back(due);
                end
                restart_state();
            end
            default: ;
        endcase
    endtask

    task automatic check_digest_byte();
        digest_out_t due;
        if (digest_due_q.size() == 0) begin
            $error("digest byte %02h at position %0d arrived with none expected",
                   i_digest_byte, i_byte_position);
            o_mismatches++;
        end else begin
            due = digest_due_q.pop_front();
            if (i_digest_byte !== due.digest) begin
                $error("digest_byte: expected %02h, got %02h", due.digest, i_digest_byte);
                o_mismatches++;
            end
            if (i_byte_position !== due.pos) begin
                $error("byte_position: expected %0d, got %0d", due.pos, i_byte_position);
                o_mismatches++;
            end
            if (i_last_byte !== due.last) begin
                $error("last_byte: expected %0b, got %0b", due.last, i_last_byte);
                o_mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_state();
            digest_due_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_digest_byte();
            if (i_in_valid && !i_in_stall) md4_take_item(i_action, i_data_byte);
        end
        o_pending = digest_due_q.size();
    end

endmodule

[dv/md4_digest_engine_tb.sv]
`timescale 1ns / 100ps

module md4_digest_engine_tb;

    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_ITEMS  = 135;
    localparam int DRAIN_CYCLES = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_action;
    logic [7:0] i_data_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_digest_byte;
    logic [3:0] o_byte_position;
    logic       o_last_byte;

    int mismatches;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    int items_sent  = 0;
    int digests     = 0;
    int restarts    = 0;
    int unused_seen = 0;

    md4_digest_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_digest_byte   (o_digest_byte),
        .o_byte_position (o_byte_position),
        .o_last_byte     (o_last_byte)
    );

    md4_digest_engine_chk chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_digest_byte   (o_digest_byte),
        .i_byte_position (o_byte_position),
        .i_last_byte     (o_last_byte),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stall, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] data);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_in_stall);
        case (act)
            md4_pkg::ACT_FINISH:  digests++;
            md4_pkg::ACT_RESTART: restarts++;
            md4_pkg::ACT_UNUSED:  unused_seen++;
            default: ;
        endcase
        if (act != md4_pkg::ACT_UNUSED) items_sent++;
    endtask

    initial begin
        int phase_end;
        int len;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = md4_pkg::ACT_ABSORB;
        i_data_byte = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, unused code, byte extremes, restart mid-message
        send_item(md4_pkg::ACT_UNUSED, 8'hFF);
        send_item(md4_pkg::ACT_FINISH, 8'h00);
        send_item(md4_pkg::ACT_ABSORB, 8'hFF);
        send_item(md4_pkg::ACT_UNUSED, 8'hA5);
        send_item(md4_pkg::ACT_ABSORB, 8'h00);
        send_item(md4_pkg::ACT_FINISH, 8'h5A);
        send_item(md4_pkg::ACT_ABSORB, 8'h61);
        send_item(md4_pkg::ACT_ABSORB, 8'h62);
        send_item(md4_pkg::ACT_RESTART, 8'hC3);
        send_item(md4_pkg::ACT_FINISH, 8'hFF);
        send_item(md4_pkg::ACT_ABSORB, 8'h61);
        send_item(md4_pkg::ACT_ABSORB, 8'h62);
        send_item(md4_pkg::ACT_ABSORB, 8'h63);
        send_item(md4_pkg::ACT_FINISH, 8'h3C);
        send_item(md4_pkg::ACT_RESTART, 8'h00);
        send_item(md4_pkg::ACT_FINISH, 8'h80);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 20; rx_idle_pct = 75; end
                1: begin tx_idle_pct = 75; rx_idle_pct = 20; end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_req    = 1'b1;
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(99) < 70) begin
                    len = $urandom_range(0, 20);
                end else if ($urandom_range(99) < 50) begin
                    case ($urandom_range(0, 7))
                        0: len = 55;
                        1: len = 56;
                        2: len = 57;
                        3: len = 63;
                        4: len = 64;
                        5: len = 65;
                        6: len = 119;
                        default: len = 120;
                    endcase
                end else begin
                    len = $urandom_range(21, 70);
                end
                for (int n = 0; n < len; n++) begin
                    if ($urandom_range(99) < 3)
                        send_item(md4_pkg::ACT_UNUSED, 8'($urandom_range(0, 255)));
                    if ($urandom_range(199) == 0)
                        send_item(md4_pkg::ACT_RESTART, 8'($urandom_range(0, 255)));
                    send_item(md4_pkg::ACT_ABSORB, 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(99) < 90)
                    send_item(md4_pkg::ACT_FINISH, 8'($urandom_range(0, 255)));
                else
                    send_item(md4_pkg::ACT_RESTART, 8'($urandom_range(0, 255)));
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items in three throttling phases: %0d digests, %0d restarts, %0d unused codes",
                 items_sent, digests, restarts, unused_seen);
        $display("Lengths spanned empty to two blocks, incl. a %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/md4_pkg.sv
src/md4_front.sv
src/md4_core.sv
src/md4_digest_engine.sv
dv/md4_digest_engine_chk.sv
dv/md4_digest_engine_tb.sv
